/* rtl/sit_pkg.sv */
// shared types, constants and codes for the sorted insert table
`timescale 1ns / 1ps

package sit_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int KEY_BITS    = 32;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;

  typedef logic [KEY_BITS-1:0] key_t;
  typedef logic [15:0]         tag_t;
  typedef logic [ADDR_W-1:0]   addr_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  typedef enum logic [1:0] {
    ORD_APPEND = 2'd0,
    ORD_ASC    = 2'd1,
    ORD_DESC   = 2'd2
  } order_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_OOB  = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_READ   = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    RD_IDX,
    RD_IDX_M1,
    RD_RIDX
  } rd_sel_t;

  typedef enum logic [1:0] {
    RES_INS_OK,
    RES_FULL,
    RES_OOB,
    RES_READ
  } res_kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SH_RD,
    S_SH_WR,
    S_INS,
    S_RD_OUT
  } state_t;

  typedef struct packed {
    logic [0:0]  operation;
    logic [31:0] entry_price;
    logic [15:0] entry_tag;
    logic [5:0]  read_index;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  position;
    logic [31:0] read_price;
    logic [15:0] read_tag;
    logic [6:0]  entry_count;
  } out_word_t;

  typedef struct packed {
    logic      latch;
    logic      idx_clr;
    logic      idx_inc;
    logic      idx_dec;
    logic      idx_load_count;
    logic      slot_from_idx;
    logic      slot_from_count;
    logic      rd_en;
    rd_sel_t   rd_sel;
    logic      wr_shift;
    logic      wr_new;
    logic      count_inc;
    logic      emit;
    res_kind_t emit_kind;
  } sit_cmd_t;

  typedef struct packed {
    logic is_read;
    logic oob;
    logic full;
    logic sorted;
    logic idx_at_count;
    logic idx_at_slot;
    logic match;
  } sit_stat_t;

endpackage

/* rtl/sit_ctrl.sv */
// controller state machine: search, shift and insert sequencing
`timescale 1ns / 1ps

module sit_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  sit_pkg::sit_stat_t stat,
  output sit_pkg::sit_cmd_t  cmd
);

  sit_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sit_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != sit_pkg::S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    cmd.rd_sel    = sit_pkg::RD_IDX;
    cmd.emit_kind = sit_pkg::RES_INS_OK;
    case (state_r)
      sit_pkg::S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = sit_pkg::S_DECODE;
        end
      end
      sit_pkg::S_DECODE: begin
        if (stat.is_read) begin
          if (stat.oob) begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = sit_pkg::RES_OOB;
            state_nxt     = sit_pkg::S_IDLE;
          end else begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = sit_pkg::RD_RIDX;
            state_nxt  = sit_pkg::S_RD_OUT;
          end
        end else if (stat.full) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = sit_pkg::RES_FULL;
          state_nxt     = sit_pkg::S_IDLE;
        end else if (stat.sorted) begin
          cmd.idx_clr = 1'b1;
          state_nxt   = sit_pkg::S_SRCH_RD;
        end else begin
          cmd.slot_from_count = 1'b1;
          state_nxt           = sit_pkg::S_INS;
        end
      end
      sit_pkg::S_SRCH_RD: begin
        if (stat.idx_at_count) begin
          // ran off the end: goes after every stored entry
          cmd.slot_from_count = 1'b1;
          cmd.idx_load_count  = 1'b1;
          state_nxt           = sit_pkg::S_SH_RD;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = sit_pkg::RD_IDX;
          state_nxt  = sit_pkg::S_SRCH_CMP;
        end
      end
      sit_pkg::S_SRCH_CMP: begin
        if (stat.match) begin
          cmd.slot_from_idx  = 1'b1;
          cmd.idx_load_count = 1'b1;
          state_nxt          = sit_pkg::S_SH_RD;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = sit_pkg::S_SRCH_RD;
        end
      end
      sit_pkg::S_SH_RD: begin
        if (stat.idx_at_slot) begin
          state_nxt = sit_pkg::S_INS;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = sit_pkg::RD_IDX_M1;
          state_nxt  = sit_pkg::S_SH_WR;
        end
      end
      sit_pkg::S_SH_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_dec  = 1'b1;
        state_nxt    = sit_pkg::S_SH_RD;
      end
      sit_pkg::S_INS: begin
        cmd.wr_new    = 1'b1;
        cmd.count_inc = 1'b1;
        cmd.emit      = 1'b1;
        cmd.emit_kind = sit_pkg::RES_INS_OK;
        state_nxt     = sit_pkg::S_IDLE;
      end
      sit_pkg::S_RD_OUT: begin
        cmd.emit      = 1'b1;
        cmd.emit_kind = sit_pkg::RES_READ;
        state_nxt     = sit_pkg::S_IDLE;
      end
      default: begin
        state_nxt = sit_pkg::S_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // a word is taken only from idle, and idle always moves on to decode
  a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (state_r == sit_pkg::S_DECODE))
    else $error("accepted word did not reach decode");

  // a single emit per word: never two in a row
  a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> !cmd.emit)
    else $error("back to back emits");

  // memory is never written and read in the same cycle
  a_port_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.rd_en && (cmd.wr_shift || cmd.wr_new)))
    else $error("read and write collide");
`endif

endmodule

/* rtl/sit_dpath.sv */
// datapath: entry memory, index and slot registers, compare and result word
`timescale 1ns / 1ps

module sit_dpath (
  input  logic               clk,
  input  logic               rst_n,
  input  sit_pkg::in_word_t  in_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_data,
  input  sit_pkg::sit_cmd_t  cmd,
  output sit_pkg::sit_stat_t stat,
  output logic               out_valid,
  output sit_pkg::out_word_t out_data
);

  sit_pkg::key_t key_mem [sit_pkg::TABLE_DEPTH];
  sit_pkg::tag_t tag_mem [sit_pkg::TABLE_DEPTH];

  logic [1:0]         order_r;
  sit_pkg::in_word_t  item_r;
  sit_pkg::cnt_t      count_r, count_nxt;
  sit_pkg::cnt_t      idx_r, idx_nxt;
  sit_pkg::cnt_t      slot_r, slot_nxt;
  sit_pkg::key_t      rd_key_r;
  sit_pkg::tag_t      rd_tag_r;
  logic               out_valid_r;
  sit_pkg::out_word_t out_r, out_nxt;

  sit_pkg::key_t  new_key;
  sit_pkg::cnt_t  idx_m1;
  sit_pkg::addr_t rd_addr, wr_addr;
  sit_pkg::key_t  wr_key;
  sit_pkg::tag_t  wr_tag;
  logic           wr_en;

  assign new_key = item_r.entry_price[sit_pkg::KEY_BITS-1:0];
  assign idx_m1  = idx_r - sit_pkg::CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= sit_pkg::ORD_APPEND;
    end else if (cfg_we) begin
      order_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_r <= in_data;
    end
  end

  // status back to the controller
  always_comb begin
    stat              = '0;
    stat.is_read      = (item_r.operation == sit_pkg::OP_READ);
    stat.oob          = ({1'b0, item_r.read_index} >= count_r);
    stat.full         = (count_r == sit_pkg::CNT_W'(sit_pkg::TABLE_DEPTH));
    stat.sorted       = (order_r == sit_pkg::ORD_ASC) || (order_r == sit_pkg::ORD_DESC);
    stat.idx_at_count = (idx_r == count_r);
    stat.idx_at_slot  = (idx_r == slot_r);
    stat.match        = (order_r == sit_pkg::ORD_ASC) ? (rd_key_r >= new_key)
                                                      : (rd_key_r <= new_key);
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.count_inc) begin
      count_nxt = count_r + sit_pkg::CNT_W'(1);
    end
    idx_nxt = idx_r;
    if (cmd.idx_clr) begin
      idx_nxt = '0;
    end else if (cmd.idx_inc) begin
      idx_nxt = idx_r + sit_pkg::CNT_W'(1);
    end else if (cmd.idx_dec) begin
      idx_nxt = idx_m1;
    end else if (cmd.idx_load_count) begin
      idx_nxt = count_r;
    end
    slot_nxt = slot_r;
    if (cmd.slot_from_idx) begin
      slot_nxt = idx_r;
    end else if (cmd.slot_from_count) begin
      slot_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    slot_r <= slot_nxt;
  end

  // single read port, single write port
  always_comb begin
    case (cmd.rd_sel)
      sit_pkg::RD_IDX:    rd_addr = idx_r[sit_pkg::ADDR_W-1:0];
      sit_pkg::RD_IDX_M1: rd_addr = idx_m1[sit_pkg::ADDR_W-1:0];
      sit_pkg::RD_RIDX:   rd_addr = item_r.read_index[sit_pkg::ADDR_W-1:0];
      default:            rd_addr = idx_r[sit_pkg::ADDR_W-1:0];
    endcase
  end

  assign wr_en   = cmd.wr_shift || cmd.wr_new;
  assign wr_addr = cmd.wr_new ? slot_r[sit_pkg::ADDR_W-1:0] : idx_r[sit_pkg::ADDR_W-1:0];
  assign wr_key  = cmd.wr_new ? new_key : rd_key_r;
  assign wr_tag  = cmd.wr_new ? item_r.entry_tag : rd_tag_r;

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_key_r <= key_mem[rd_addr];
      rd_tag_r <= tag_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      tag_mem[wr_addr] <= wr_tag;
    end
  end

  // result word
  always_comb begin
    out_nxt             = '0;
    out_nxt.entry_count = 7'(count_nxt);
    case (cmd.emit_kind)
      sit_pkg::RES_INS_OK: begin
        out_nxt.status   = sit_pkg::ST_OK;
        out_nxt.position = 6'(slot_r);
      end
      sit_pkg::RES_FULL: begin
        out_nxt.status = sit_pkg::ST_FULL;
      end
      sit_pkg::RES_OOB: begin
        out_nxt.status = sit_pkg::ST_OOB;
      end
      sit_pkg::RES_READ: begin
        out_nxt.status     = sit_pkg::ST_OK;
        out_nxt.read_price = 32'(rd_key_r);
        out_nxt.read_tag   = rd_tag_r;
      end
      default: begin
        out_nxt.status = sit_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= sit_pkg::CNT_W'(sit_pkg::TABLE_DEPTH))
    else $error("fill count beyond table depth");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.count_inc |=> (count_r == $past(count_r) + sit_pkg::CNT_W'(1)))
    else $error("fill count did not step on insert");

  // shifting or inserting never writes past the current fill
  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> ((cmd.wr_new ? slot_r : idx_r) <= count_r))
    else $error("write beyond fill count");

  a_full_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status == sit_pkg::ST_FULL)
      |-> (count_r == sit_pkg::CNT_W'(sit_pkg::TABLE_DEPTH)))
    else $error("full status with room left");
`endif

endmodule

/* rtl/sorted_insert_table.sv */
// top level of the sorted insert table
`timescale 1ns / 1ps

// Bounded table of (price key, tag) entries kept in insert order, ascending or
// descending key order, as selected by the cfg_data order code.
// Input: drive in_data and raise start; the word is taken at an edge where
// start is high and busy is low. busy stays high until the result is issued.
// Output: one result word per input word, on out_data for exactly one cycle
// with out_valid high; the receiver cannot stall it.
// Config: cfg_we with cfg_data writes the order code; write it while idle.
// Steps from accept to the result:
//   read out of range or insert into a full table: decode issues it
//   read in range or unsorted append: decode, then read-out or insert state
//   sorted insert: a read and a compare step per entry compared, a read and
//   a write step per entry moved, then insert; an insert after every entry
//   moves none; slowest is a sorted insert at slot 0 of a nearly full table
// The next word is taken at the same edge that takes the result.
// The single-port entry memory sets the pace: each compare and each move of
// one entry is a read step followed by a compare or write step.
// Reset clears the fill count and the order code (append); the memory is not
// cleared, since only entries below the fill count are ever read.

module sorted_insert_table (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  sit_pkg::in_word_t  in_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_data,
  output logic               out_valid,
  output sit_pkg::out_word_t out_data
);

  sit_pkg::sit_cmd_t  cmd;
  sit_pkg::sit_stat_t stat;

  sit_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  sit_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
